// ===== hw/rtl/dmf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmf_pkg
// Shared widths, constants and codes of the duplicate message filter.
// ----------------------------------------------------------------------------
package dmf_pkg;

  // Cache geometry
  localparam int CACHE_ENTRIES = 16;
  localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(CACHE_ENTRIES - 1);

  // Field widths
  localparam int SRC_W  = 16;
  localparam int MSG_W  = 32;
  localparam int TIME_W = 32;

  // Window register reset value in ms
  localparam logic [TIME_W-1:0] DEFAULT_WINDOW_MS = TIME_W'(60000);

  // Command codes
  localparam logic CMD_CHECK = 1'b0;
  localparam logic CMD_MARK  = 1'b1;

  // Operand selection for the shared compare unit
  typedef enum logic {
    CMP_AGE_VS_WINDOW = 1'b0,  // (now - stored) < window
    CMP_TIME_VS_OLD   = 1'b1   // stored < oldest seen so far
  } cmp_sel_t;

  // Request to the shared compare unit
  typedef struct packed {
    cmp_sel_t          sel;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] stored;
    logic [TIME_W-1:0] ref_val;
  } cmp_req_t;

endpackage

// ===== hw/rtl/dmf_cmp_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmf_cmp_unit
// Shared subtract and compare unit: tests either the wrapped age of an
// entry against the window, or an entry timestamp against the oldest so far.
// ----------------------------------------------------------------------------
module dmf_cmp_unit (
  input  dmf_pkg::cmp_req_t req,
  output logic              lt
);

  logic [dmf_pkg::TIME_W-1:0] age;
  logic [dmf_pkg::TIME_W-1:0] lhs;

  // Age wraps modulo 2^TIME_W
  assign age = req.now - req.stored;

  // Operand select, then one unsigned compare
  always_comb begin
    case (req.sel)
      dmf_pkg::CMP_AGE_VS_WINDOW: lhs = age;
      dmf_pkg::CMP_TIME_VS_OLD:   lhs = req.stored;
      default:                    lhs = age;
    endcase
  end

  assign lt = (lhs < req.ref_val);

endmodule

// ===== hw/rtl/duplicate_message_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// duplicate_message_filter
// Duplicate-suppression cache of (source node, message id) pairs with
// timestamps. Check looks up the first valid match and tests its age;
// mark writes the lowest free entry or else the oldest by raw timestamp.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_command, in_source_node,
//                                            in_message_id, in_now_ms
//   out      output     out_valid/out_stall  out_is_duplicate
//   cfg      input      cfg_wr_en            cfg_wr_data (dup_window_ms)
//
// One entry is examined per cycle by the shared compare unit. A
// transaction is accepted in ST_IDLE, scans in ST_SCAN until a match, a
// free entry or the last entry, passes ST_FINISH and returns to ST_IDLE,
// where the next one is accepted. Reset clears all valid bits at once. A
// new transaction may be accepted while a result waits on out_stall; it
// then holds in ST_FINISH until the output register frees.
// ----------------------------------------------------------------------------
module duplicate_message_filter (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_command,
  input  logic [dmf_pkg::SRC_W-1:0]     in_source_node,
  input  logic [dmf_pkg::MSG_W-1:0]     in_message_id,
  input  logic [dmf_pkg::TIME_W-1:0]    in_now_ms,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_is_duplicate,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic [dmf_pkg::TIME_W-1:0]    cfg_wr_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // Sequencer state
  state_t                      state_r,  state_nxt;
  logic [dmf_pkg::IDX_W-1:0]   idx_r,    idx_nxt;
  logic [dmf_pkg::IDX_W-1:0]   pick_r,   pick_nxt;
  logic [dmf_pkg::TIME_W-1:0]  oldest_r, oldest_nxt;
  logic                        dup_r,    dup_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_dup_r,   out_dup_nxt;

  // Latched transaction
  logic                        cmd_r;
  logic [dmf_pkg::SRC_W-1:0]   src_r;
  logic [dmf_pkg::MSG_W-1:0]   msg_r;
  logic [dmf_pkg::TIME_W-1:0]  now_r;

  // Window register
  logic [dmf_pkg::TIME_W-1:0]  window_r;

  // Entry storage
  logic [dmf_pkg::CACHE_ENTRIES-1:0] valid_r;
  logic [dmf_pkg::SRC_W-1:0]         ent_src_r  [dmf_pkg::CACHE_ENTRIES];
  logic [dmf_pkg::MSG_W-1:0]         ent_msg_r  [dmf_pkg::CACHE_ENTRIES];
  logic [dmf_pkg::TIME_W-1:0]        ent_time_r [dmf_pkg::CACHE_ENTRIES];

  // Entry under scan and its match
  logic                        cur_valid;
  logic [dmf_pkg::TIME_W-1:0]  cur_time;
  logic                        cur_match;
  logic                        last;
  logic                        in_acc;

  // Entry updates from the sequencer
  logic                        wr_en;
  logic [dmf_pkg::IDX_W-1:0]   wr_idx;
  logic                        inval_en;

  dmf_pkg::cmp_req_t           cmp_req;
  logic                        cmp_lt;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_is_duplicate = out_dup_r;

  assign cur_valid = valid_r[idx_r];
  assign cur_time  = ent_time_r[idx_r];
  assign cur_match = cur_valid && (ent_src_r[idx_r] == src_r) && (ent_msg_r[idx_r] == msg_r);
  assign last      = (idx_r == dmf_pkg::TOP_IDX);

  // Shared compare unit operands
  always_comb begin
    cmp_req.now     = now_r;
    cmp_req.stored  = cur_time;
    if (cmd_r == dmf_pkg::CMD_MARK) begin
      cmp_req.sel     = dmf_pkg::CMP_TIME_VS_OLD;
      cmp_req.ref_val = oldest_r;
    end else begin
      cmp_req.sel     = dmf_pkg::CMP_AGE_VS_WINDOW;
      cmp_req.ref_val = window_r;
    end
  end

  dmf_cmp_unit u_cmp (
    .req (cmp_req),
    .lt  (cmp_lt)
  );

  // Sequencer next state
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    pick_nxt      = pick_r;
    oldest_nxt    = oldest_r;
    dup_nxt       = dup_r;
    out_valid_nxt = out_valid_r;
    out_dup_nxt   = out_dup_r;
    wr_en         = 1'b0;
    wr_idx        = idx_r;
    inval_en      = 1'b0;

    // result taken downstream
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt  = ST_SCAN;
          idx_nxt    = '0;
          pick_nxt   = '0;
          oldest_nxt = '0;
          dup_nxt    = 1'b0;
        end
      end
      ST_SCAN: begin
        if (cmd_r == dmf_pkg::CMD_CHECK) begin
          // first match ends the scan: fresh reports, stale is dropped
          if (cur_match) begin
            state_nxt = ST_FINISH;
            if (cmp_lt) begin
              dup_nxt = 1'b1;
            end else begin
              inval_en = 1'b1;
            end
          end else if (last) begin
            state_nxt = ST_FINISH;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else begin
          // lowest free entry wins, else oldest raw timestamp
          if (!cur_valid) begin
            wr_en     = 1'b1;
            wr_idx    = idx_r;
            state_nxt = ST_FINISH;
          end else begin
            if ((idx_r == '0) || cmp_lt) begin
              oldest_nxt = cur_time;
              pick_nxt   = idx_r;
            end
            if (last) begin
              wr_en     = 1'b1;
              wr_idx    = ((idx_r == '0) || cmp_lt) ? idx_r : pick_r;
              state_nxt = ST_FINISH;
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end
        end
      end
      ST_FINISH: begin
        // wait for the output register to free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_dup_nxt   = dup_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      pick_r      <= '0;
      oldest_r    <= '0;
      dup_r       <= 1'b0;
      out_valid_r <= 1'b0;
      out_dup_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      pick_r      <= pick_nxt;
      oldest_r    <= oldest_nxt;
      dup_r       <= dup_nxt;
      out_valid_r <= out_valid_nxt;
      out_dup_r   <= out_dup_nxt;
    end
  end

  // Transaction capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= in_command;
      src_r <= in_source_node;
      msg_r <= in_message_id;
      now_r <= in_now_ms;
    end
  end

  // Window register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= dmf_pkg::DEFAULT_WINDOW_MS;
    end else if (cfg_wr_en) begin
      window_r <= cfg_wr_data;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_idx] <= 1'b1;
    end else if (inval_en) begin
      valid_r[idx_r] <= 1'b0;
    end
  end

  // Entry payload
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent_src_r[wr_idx]  <= src_r;
      ent_msg_r[wr_idx]  <= msg_r;
      ent_time_r[wr_idx] <= now_r;
    end
  end

endmodule

// ===== tb/duplicate_message_filter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// duplicate_message_filter_test
// Self-checking bench for the duplicate message filter. A directed sequence
// covers empty lookups, fresh and stale matches, timestamp wrap, first-match
// invalidation and eviction by oldest stamp with ties. It is followed by
// random check/mark traffic over a small pool of pairs, under several window
// settings and handshake idling patterns. Results are compared in order
// against a cache predictor held in a scoreboard.
// ----------------------------------------------------------------------------
module duplicate_message_filter_test;

  typedef logic [dmf_pkg::SRC_W-1:0]  src_t;
  typedef logic [dmf_pkg::MSG_W-1:0]  msg_t;
  typedef logic [dmf_pkg::TIME_W-1:0] ms_t;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 6;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int SETTLE       = 20;
  localparam int HOLD_CYCLES  = 300;
  localparam int POOL_SIZE    = 24;
  localparam int NUM_PHASES   = 6;
  localparam int PHASE_ITEMS  = 105;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts the cache and checks results in order
  // --------------------------------------------------------------------------
  class dup_scoreboard;
    ms_t  window_ms;
    logic entry_live  [dmf_pkg::CACHE_ENTRIES];
    src_t entry_src   [dmf_pkg::CACHE_ENTRIES];
    msg_t entry_msg   [dmf_pkg::CACHE_ENTRIES];
    ms_t  entry_stamp [dmf_pkg::CACHE_ENTRIES];
    logic expected_dup [$];
    int   mismatches;
    int   checks;
    int   marks;
    int   dups_seen;

    function new();
      window_ms = dmf_pkg::DEFAULT_WINDOW_MS;
      foreach (entry_live[i]) begin
        entry_live[i]  = 1'b0;
        entry_src[i]   = '0;
        entry_msg[i]   = '0;
        entry_stamp[i] = '0;
      end
      mismatches = 0;
      checks     = 0;
      marks      = 0;
      dups_seen  = 0;
    endfunction

    function int pending();
      return expected_dup.size();
    endfunction

    // Accepted input transaction: update the cache copy, queue the expected flag
    function void note_transaction(logic cmd, src_t src, msg_t msg, ms_t now);
      logic dup;
      logic done;
      int   pick;
      ms_t  oldest;
      dup  = 1'b0;
      done = 1'b0;
      pick = 0;
      oldest = '0;
      if (cmd == dmf_pkg::CMD_CHECK) begin
        checks++;
        // first live match decides; a stale one is dropped and the scan stops
        for (int i = 0; i < dmf_pkg::CACHE_ENTRIES; i++) begin
          if (!done && entry_live[i] && entry_src[i] == src && entry_msg[i] == msg) begin
            done = 1'b1;
            if (ms_t'(now - entry_stamp[i]) < window_ms) dup = 1'b1;
            else entry_live[i] = 1'b0;
          end
        end
      end else begin
        marks++;
        // lowest free slot, else smallest raw stamp (lowest index on a tie)
        for (int i = 0; i < dmf_pkg::CACHE_ENTRIES; i++) begin
          if (!done) begin
            if (!entry_live[i]) begin
              pick = i;
              done = 1'b1;
            end else if (i == 0 || entry_stamp[i] < oldest) begin
              oldest = entry_stamp[i];
              pick   = i;
            end
          end
        end
        entry_live[pick]  = 1'b1;
        entry_src[pick]   = src;
        entry_msg[pick]   = msg;
        entry_stamp[pick] = now;
      end
      expected_dup.push_back(dup);
    endfunction

    // Accepted result transaction: compare with the oldest expectation
    function void check_result(logic actual);
      logic want;
      if (expected_dup.size() == 0) begin
        $display("%0t: result with nothing pending, expected none, actual is_duplicate=%0b",
                 $time, actual);
        mismatches++;
      end else begin
        want = expected_dup.pop_front();
        if (actual !== want) begin
          $display("%0t: is_duplicate mismatch, expected %0b, actual %0b",
                   $time, want, actual);
          mismatches++;
        end
        if (actual === 1'b1) dups_seen++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals
  // --------------------------------------------------------------------------
  logic clk              = 1'b0;
  logic rst_n            = 1'b0;
  logic in_valid         = 1'b0;
  logic in_stall;
  logic in_command       = dmf_pkg::CMD_CHECK;
  src_t in_source_node   = '0;
  msg_t in_message_id    = '0;
  ms_t  in_now_ms        = '0;
  logic out_valid;
  logic out_stall        = 1'b0;
  logic out_is_duplicate;
  logic cfg_wr_en        = 1'b0;
  ms_t  cfg_wr_data      = '0;

  dup_scoreboard board = new();

  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_req       = 1'b0;
  logic hold_seen      = 1'b0;
  int   hold_left      = 0;
  int   cycle_count    = 0;
  int   items_sent     = 0;

  // stimulus pool of pairs and the time each was last marked
  src_t pool_src   [POOL_SIZE];
  msg_t pool_msg   [POOL_SIZE];
  ms_t  pool_stamp [POOL_SIZE];
  ms_t  clock_ms;

  duplicate_message_filter DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_source_node   (in_source_node),
    .in_message_id    (in_message_id),
    .in_now_ms        (in_now_ms),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_is_duplicate (out_is_duplicate),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  always #CLK_HALF clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, board.pending());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Monitor both channels; results first, they belong to earlier inputs
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) board.check_result(out_is_duplicate);
      if (in_valid && !in_stall)
        board.note_transaction(in_command, in_source_node, in_message_id, in_now_ms);
    end
  end

  // Receiver: random stall, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------
  task automatic send_transaction(input logic cmd, input src_t src, input msg_t msg,
                                  input ms_t now);
    int gap;
    gap = 0;
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_source_node <= src;
    in_message_id  <= msg;
    in_now_ms      <= now;
    do @(posedge clk); while (in_stall);
    items_sent++;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sender pauses until every expected result is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_window(input ms_t value);
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    board.window_ms = value;
  endtask

  task automatic refill_pool();
    for (int i = 0; i < POOL_SIZE; i++) begin
      // every third pair shares its source with the previous one
      pool_src[i]   = (i % 3 == 2) ? pool_src[i-1] : src_t'($urandom);
      pool_msg[i]   = $urandom;
      pool_stamp[i] = clock_ms;
    end
  endtask

  // One random check or mark, mostly on pool pairs
  task automatic random_transaction();
    int   k;
    int   r;
    int   s;
    logic cmd;
    src_t src;
    msg_t msg;
    ms_t  now;
    k   = $urandom_range(POOL_SIZE - 1);
    cmd = ($urandom_range(99) < 40) ? dmf_pkg::CMD_MARK : dmf_pkg::CMD_CHECK;
    src = pool_src[k];
    msg = pool_msg[k];
    r   = $urandom_range(99);
    if (r < 6) begin
      src = src_t'($urandom);
      msg = $urandom;
    end else if (r < 10) begin
      msg[$urandom_range(dmf_pkg::MSG_W - 1)] ^= 1'b1;   // near miss
    end
    s = $urandom_range(99);
    if (s < 45) clock_ms += $urandom_range(3);
    else if (s < 72) clock_ms += $urandom_range(board.window_ms >> 3);
    else if (s < 95 && s >= 90) clock_ms = $urandom;
    else if (s >= 95) clock_ms += board.window_ms;
    now = clock_ms;
    // age right at the window edge
    if (s >= 72 && s < 90 && cmd == dmf_pkg::CMD_CHECK)
      now = pool_stamp[k] + board.window_ms + ms_t'($urandom_range(2)) - ms_t'(1);
    send_transaction(cmd, src, msg, now);
    if (cmd == dmf_pkg::CMD_MARK && r >= 10) pool_stamp[k] = now;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    ms_t next_window;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset window
    send_transaction(dmf_pkg::CMD_CHECK, 16'h0000, 32'h0000_0000, 32'd0);     // empty cache
    send_transaction(dmf_pkg::CMD_MARK,  16'hFFFF, 32'hFFFF_FFFF, 32'd0);
    send_transaction(dmf_pkg::CMD_CHECK, 16'hFFFF, 32'hFFFF_FFFF, 32'd59999); // fresh
    send_transaction(dmf_pkg::CMD_CHECK, 16'hFFFF, 32'hFFFF_FFFF, 32'd60000); // stale, dropped
    send_transaction(dmf_pkg::CMD_CHECK, 16'hFFFF, 32'hFFFF_FFFF, 32'd60000); // now gone
    send_transaction(dmf_pkg::CMD_MARK,  16'h0000, 32'h0000_0000, 32'hFFFF_FFF0);
    send_transaction(dmf_pkg::CMD_MARK,  16'h0000, 32'h0000_0000, 32'd100);   // same pair again
    send_transaction(dmf_pkg::CMD_CHECK, 16'h0000, 32'h0000_0000, 32'd200);   // age across wrap
    // first match stale, scan stops there; second copy is fresh next time
    send_transaction(dmf_pkg::CMD_CHECK, 16'h0000, 32'h0000_0000, 32'd60000);
    send_transaction(dmf_pkg::CMD_CHECK, 16'h0000, 32'h0000_0000, 32'd60000);
    send_transaction(dmf_pkg::CMD_CHECK, 16'h0001, 32'h0000_0000, 32'd60000); // source differs
    // fill the cache; three entries tie on the oldest stamp
    for (int i = 0; i < 15; i++)
      send_transaction(dmf_pkg::CMD_MARK, src_t'(16'h5A00 + i), msg_t'(32'hA5A5_0000 + i),
                       (i == 3 || i == 9) ? ms_t'(100) : ms_t'(70000 + i));
    send_transaction(dmf_pkg::CMD_MARK,  16'hBEEF, 32'hDEAD_BEEF, 32'd80000); // evicts lowest tie
    send_transaction(dmf_pkg::CMD_CHECK, 16'h0000, 32'h0000_0000, 32'd80000);
    wait_drained();

    // Random phases, each with its own window and idling pattern
    clock_ms = $urandom;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       next_window = 32'd1;
        1:       next_window = 32'hFFFF_FFFF;
        2:       next_window = 32'd0;
        3:       next_window = 32'd250;
        4:       next_window = ms_t'($urandom_range(100000, 1));
        default: next_window = dmf_pkg::DEFAULT_WINDOW_MS;
      endcase
      write_window(next_window);
      case (ph % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1:       begin send_idle_pct = 78; recv_stall_pct <= 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct <= 78; end
        default: begin send_idle_pct = 13; recv_stall_pct <= 13; end
      endcase
      // some phases start just short of the timestamp wrap
      if (ph % 2 == 1) clock_ms = 32'hFFFF_FFFF - ms_t'($urandom_range(2000));
      refill_pool();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 0 && n == 20) hold_req <= ~hold_req;   // sender keeps going, block backs up
        if (n == 60) wait_drained();
        random_transaction();
      end
      wait_drained();
    end

    repeat (SETTLE * 2) @(posedge clk);
    $display("Ran %0d transactions (%0d checks, %0d marks, %0d duplicates) under %0d windows,",
             items_sent, board.checks, board.marks, board.dups_seen, NUM_PHASES + 1);
    $display("including zero, one and full-range windows, wrap, eviction ties and back-pressure.");
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
